FILE: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds command codes, the classified operation item, queue sizing and back-end states.
// No dependencies.
package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic CFG_FOREGROUND = 1'b0;
	localparam logic CFG_BACKGROUND = 1'b1;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_RETURN  = 8'd13;
	localparam logic [7:0] CHAR_BLANK   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h0F;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_NEWLINE,
		OP_RETURN,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_BLANK_ROW,
		ST_CLEAR
	} back_state_t;

endpackage

FILE: sv/text_console_writer_unit.sv
// Text console writer: one front stage, a two-item queue, then the back end, which takes one item at a time.
// After the queue, put, return and no-op results are registered directly; a read passes through ST_READ,
// a scrolling put through ST_BLANK_ROW, a clear through ST_CLEAR. Back-end memory port bounds throughput.
// Throughput: one item per cycle for ordinary puts and reads out of range while out_ready is high; a read
// blocks the next item in ST_READ. Reset: cursor homes, colors go to 15 on 0, and a sweep blanks the screen
// with attribute 0x0F while in_ready stays low; configuration writes are taken throughout.
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_column,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attribute,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_column
);

	logic [3:0] fg_q;
	logic [3:0] bg_q;
	logic       init_busy;
	logic       push_valid, push_ready;
	op_t        push_op;
	logic       pop_valid, pop_ready;
	op_t        pop_op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd15;
			bg_q <= 4'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FOREGROUND: fg_q <= cfg_data;
				CFG_BACKGROUND: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.init_busy  (init_busy),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_column(read_column),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_op   (push_op),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.attr          ({bg_q, fg_q}),
		.init_busy     (init_busy),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_op        (pop_op),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cell_char     (cell_char),
		.cell_attribute(cell_attribute),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column)
	);

endmodule

FILE: sv/tcw_front.sv
// Front end: accepts command items, classifies them and registers the operation.
// Depends on tcw_pkg.
module tcw_front
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       init_busy,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_column,
	output logic       push_valid,
	input  logic       push_ready,
	output op_t        push_op
);

	logic valid_s1;
	op_t  op_s1;
	op_t  op_d;
	logic accept;
	logic read_ok;

	assign in_ready   = !init_busy && (!valid_s1 || push_ready);
	assign accept     = in_valid && in_ready;
	assign push_valid = valid_s1;
	assign push_op    = op_s1;
	assign read_ok    = (32'(read_row) < ROWS) && (32'(read_column) < COLUMNS);

	always_comb begin
		op_d.ch  = char_code;
		op_d.row = read_row;
		op_d.col = read_column;
		case (cmd)
			CMD_PUT: begin
				if (char_code == CHAR_NEWLINE) begin
					op_d.kind = OP_NEWLINE;
				end else if (char_code == CHAR_RETURN) begin
					op_d.kind = OP_RETURN;
				end else begin
					op_d.kind = OP_WRITE;
				end
			end
			CMD_CLEAR: op_d.kind = OP_CLEAR;
			CMD_READ: op_d.kind = read_ok ? OP_READ : OP_NOP;
			default: op_d.kind = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !push_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

endmodule

FILE: sv/tcw_queue.sv
// Short operation queue between the front and back ends.
// Depends on tcw_pkg.
module tcw_queue
	import tcw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR  = PW'(QUEUE_DEPTH - 1);
	localparam logic [NW-1:0] FULL_CNT  = NW'(QUEUE_DEPTH);

	op_t           entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

FILE: sv/tcw_back.sv
// Back end: executes operations on the screen memory, owns the cursor and the result register.
// Scroll rotates a row base and blanks one row; clear and reset sweep the whole screen.
// Depends on tcw_pkg.
module tcw_back
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] attr,
	output logic       init_busy,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  op_t        pop_op,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attribute,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_column
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = ROWS * (1 << CW);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
	localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	back_state_t   state_q, state_d;
	logic [RW-1:0] cur_row_q, cur_row_d;
	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [RW-1:0] base_q, base_d;
	logic [RW-1:0] sweep_row_q, sweep_row_d;
	logic [CW-1:0] sweep_col_q, sweep_col_d;
	logic [7:0]    sweep_attr_q, sweep_attr_d;
	logic          init_q, init_d;
	logic          out_valid_q, out_valid_d;
	logic [7:0]    cell_char_q, cell_char_d;
	logic [7:0]    cell_attr_q, cell_attr_d;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;

	logic [RW:0]   cur_sum, rd_sum;
	logic [RW-1:0] cur_phys, rd_phys, base_inc, rd_row;
	logic          out_free;

	assign init_busy      = init_q;
	assign out_valid      = out_valid_q;
	assign cell_char      = cell_char_q;
	assign cell_attribute = cell_attr_q;
	assign cursor_row     = 5'(cur_row_q);
	assign cursor_column  = 7'(cur_col_q);

	assign rd_row    = RW'(pop_op.row);
	assign cur_sum   = {1'b0, cur_row_q} + {1'b0, base_q};
	assign rd_sum    = {1'b0, rd_row} + {1'b0, base_q};
	assign cur_phys  = (cur_sum >= ROWS_W) ? RW'(cur_sum - ROWS_W) : RW'(cur_sum);
	assign rd_phys   = (rd_sum >= ROWS_W) ? RW'(rd_sum - ROWS_W) : RW'(rd_sum);
	assign base_inc  = (base_q == LAST_ROW) ? '0 : base_q + 1'b1;
	assign mem_raddr = {rd_phys, CW'(pop_op.col)};
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cur_row_d    = cur_row_q;
		cur_col_d    = cur_col_q;
		base_d       = base_q;
		sweep_row_d  = sweep_row_q;
		sweep_col_d  = sweep_col_q;
		sweep_attr_d = sweep_attr_q;
		init_d       = init_q;
		out_valid_d  = out_valid_q && !out_ready;
		cell_char_d  = cell_char_q;
		cell_attr_d  = cell_attr_q;
		pop_ready    = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = {sweep_row_q, sweep_col_q};
		mem_wdata    = {sweep_attr_q, CHAR_BLANK};

		case (state_q)
			ST_IDLE: begin
				if (pop_valid && out_free) begin
					pop_ready = 1'b1;
					case (pop_op.kind)
						OP_WRITE, OP_NEWLINE: begin
							if (pop_op.kind == OP_WRITE) begin
								mem_we    = 1'b1;
								mem_waddr = {cur_phys, cur_col_q};
								mem_wdata = {attr, pop_op.ch};
							end
							if (pop_op.kind == OP_WRITE && cur_col_q != LAST_COL) begin
								cur_col_d   = cur_col_q + 1'b1;
								out_valid_d = 1'b1;
								cell_char_d = '0;
								cell_attr_d = '0;
							end else begin
								cur_col_d = '0;
								if (cur_row_q == LAST_ROW) begin
									base_d       = base_inc;
									sweep_row_d  = base_q;
									sweep_col_d  = '0;
									sweep_attr_d = attr;
									state_d      = ST_BLANK_ROW;
								end else begin
									cur_row_d   = cur_row_q + 1'b1;
									out_valid_d = 1'b1;
									cell_char_d = '0;
									cell_attr_d = '0;
								end
							end
						end
						OP_RETURN: begin
							cur_col_d   = '0;
							out_valid_d = 1'b1;
							cell_char_d = '0;
							cell_attr_d = '0;
						end
						OP_CLEAR: begin
							cur_row_d    = '0;
							cur_col_d    = '0;
							base_d       = '0;
							sweep_row_d  = '0;
							sweep_col_d  = '0;
							sweep_attr_d = attr;
							state_d      = ST_CLEAR;
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						default: begin
							out_valid_d = 1'b1;
							cell_char_d = '0;
							cell_attr_d = '0;
						end
					endcase
				end
			end
			ST_READ: begin
				out_valid_d = 1'b1;
				cell_char_d = rdata_q[7:0];
				cell_attr_d = rdata_q[15:8];
				state_d     = ST_IDLE;
			end
			ST_BLANK_ROW: begin
				mem_we = 1'b1;
				if (sweep_col_q == LAST_COL) begin
					state_d     = ST_IDLE;
					out_valid_d = 1'b1;
					cell_char_d = '0;
					cell_attr_d = '0;
				end else begin
					sweep_col_d = sweep_col_q + 1'b1;
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_col_q == LAST_COL) begin
					sweep_col_d = '0;
					if (sweep_row_q == LAST_ROW) begin
						state_d = ST_IDLE;
						if (init_q) begin
							init_d = 1'b0;
						end else begin
							out_valid_d = 1'b1;
							cell_char_d = '0;
							cell_attr_d = '0;
						end
					end else begin
						sweep_row_d = sweep_row_q + 1'b1;
					end
				end else begin
					sweep_col_d = sweep_col_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			base_q       <= '0;
			sweep_row_q  <= '0;
			sweep_col_q  <= '0;
			sweep_attr_q <= RESET_ATTR;
			init_q       <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cur_row_q    <= cur_row_d;
			cur_col_q    <= cur_col_d;
			base_q       <= base_d;
			sweep_row_q  <= sweep_row_d;
			sweep_col_q  <= sweep_col_d;
			sweep_attr_q <= sweep_attr_d;
			init_q       <= init_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cell_char_q <= cell_char_d;
		cell_attr_q <= cell_attr_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

endmodule
